### rtl/wfts_pkg.sv
// ----------------------------------------------------------------------------
// wfts_pkg
// Shared types and constants of the weighted fair thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package wfts_pkg;

   localparam int unsigned KEY_W      = 64;
   localparam int unsigned TIME_W     = 40;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned PRIO_W     = 6;
   localparam int unsigned WEIGHT_W   = 24;
   localparam int unsigned CMD_W      = 3;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned TICKS_W    = 32;
   localparam int unsigned LIMIT_W    = 32;

   localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SETPRI = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WAKE   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_THR  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE_RUN = 3'd4;

   localparam logic [PRIO_W-1:0]  PRIO_DEFAULT = 6'd20;
   localparam logic [PRIO_W-1:0]  PRIO_MAX     = 6'd39;
   localparam logic [CNT_W-1:0]   COUNT_MAX    = 16'hFFFF;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 32'd2000000;

   // per-slot record held by one cell
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
      logic              runnable;
      logic              used;
      logic [CNT_W-1:0]  yields;
      logic [TIME_W-1:0] run_time;
   } slot_type;

   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [PRIO_W-1:0] p);
      logic [WEIGHT_W-1:0] w;
      unique case (p)
         6'd0:  w = 24'd10000000; 6'd1:  w = 24'd7943282; 6'd2:  w = 24'd6309573;
         6'd3:  w = 24'd5011872;  6'd4:  w = 24'd3981071; 6'd5:  w = 24'd3162277;
         6'd6:  w = 24'd2511886;  6'd7:  w = 24'd1995262; 6'd8:  w = 24'd1584893;
         6'd9:  w = 24'd1258925;  6'd10: w = 24'd1000000; 6'd11: w = 24'd794328;
         6'd12: w = 24'd630957;   6'd13: w = 24'd501187;  6'd14: w = 24'd398107;
         6'd15: w = 24'd316227;   6'd16: w = 24'd251188;  6'd17: w = 24'd199526;
         6'd18: w = 24'd158489;   6'd19: w = 24'd125892;  6'd20: w = 24'd100000;
         6'd21: w = 24'd79432;    6'd22: w = 24'd63095;   6'd23: w = 24'd50118;
         6'd24: w = 24'd39810;    6'd25: w = 24'd31622;   6'd26: w = 24'd25118;
         6'd27: w = 24'd19952;    6'd28: w = 24'd15848;   6'd29: w = 24'd12589;
         6'd30: w = 24'd10000;    6'd31: w = 24'd7943;    6'd32: w = 24'd6309;
         6'd33: w = 24'd5011;     6'd34: w = 24'd3981;    6'd35: w = 24'd3162;
         6'd36: w = 24'd2511;     6'd37: w = 24'd1995;    6'd38: w = 24'd1584;
         default: w = 24'd1258;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

### rtl/wfts_cell.sv
// ----------------------------------------------------------------------------
// wfts_cell
// One slot of the rotating thread table: holds a record and passes it on.
// ----------------------------------------------------------------------------
`default_nettype none
module wfts_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wfts_pkg::slot_type     reset_value,
   input  wfts_pkg::slot_type     slot_in,
   output wfts_pkg::slot_type     slot_out
);
   import wfts_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= reset_value;
      end else if (shift) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule
`default_nettype wire

### rtl/weighted_fair_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// weighted_fair_thread_scheduler_core
// Thread table scheduler with minimum virtual runtime selection.
// ----------------------------------------------------------------------------
// Usage: a request (req_command, req_elapsed_ticks, req_thread_index,
// req_new_priority) is taken when req_valid and req_ready are high. Exactly
// one response (rsp_status, rsp_running_thread, rsp_switched,
// rsp_created_thread) follows on the rsp_ channel per request.
// The thread table sits in a ring of MAX_THREADS cells that rotates one
// slot per cycle while a pass is in work. A first full rotation updates the
// table; when a reselection is needed the weight multiply follows (S_MUL0,
// S_MUL1) and a second rotation adds the product to the running thread's key
// and scans for the minimum key. The 40x24 multiply is cut in two 20-bit
// halves of the runtime.
// One request is in work at a time; req_ready is low from acceptance until
// the response has been handed off to the output register.
// A stalled rsp_ready holds the response in its register; the next request
// may be accepted and worked on meanwhile, but its response waits.
// Synchronous reset restores the table (slot 0 used and runnable, priority
// 20, keys zero), the time limit to 2000000 and drops any pending response.
// csr_write_enable loads the time limit at once.
// ----------------------------------------------------------------------------
`default_nettype none
module weighted_fair_thread_scheduler_core #(
   parameter int unsigned MAX_THREADS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [wfts_pkg::CMD_W-1:0]     req_command,
   input  wire logic [wfts_pkg::TICKS_W-1:0]   req_elapsed_ticks,
   input  wire logic [wfts_pkg::IDX_W-1:0]     req_thread_index,
   input  wire logic [wfts_pkg::PRIO_W-1:0]    req_new_priority,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [wfts_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [wfts_pkg::IDX_W-1:0]     rsp_running_thread,
   output      logic                           rsp_switched,
   output      logic [wfts_pkg::IDX_W-1:0]     rsp_created_thread,
   input  wire logic                           csr_write_enable,
   input  wire logic [wfts_pkg::LIMIT_W-1:0]   csr_write_data
);
   import wfts_pkg::*;

   localparam int unsigned SLOT_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int unsigned POS_W  = $clog2(MAX_THREADS + 1);
   localparam int unsigned PART_W = TIME_W / 2 + WEIGHT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PASS1 = 3'd1;
   localparam logic [2:0] S_MUL0  = 3'd2;
   localparam logic [2:0] S_MUL1  = 3'd3;
   localparam logic [2:0] S_PASS2 = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   // ring: cell i feeds from cell i+1; head is cell 0, fed back at the tail
   slot_type ring_q [MAX_THREADS];
   slot_type ring_d [MAX_THREADS];
   slot_type head_new;
   logic     shift;

   genvar g;
   generate
      for (g = 0; g < MAX_THREADS; g++) begin : g_cell
         slot_type rv;
         always_comb begin
            rv.key      = '0;
            rv.prio     = PRIO_DEFAULT;
            rv.runnable = (g == 0);
            rv.used     = (g == 0);
            rv.yields   = '0;
            rv.run_time = '0;
         end
         if (g == MAX_THREADS - 1) begin : g_tail
            assign ring_d[g] = head_new;
         end else begin : g_mid
            assign ring_d[g] = ring_q[g+1];
         end
         wfts_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .reset_value (rv),
            .slot_in     (ring_d[g]),
            .slot_out    (ring_q[g])
         );
      end
   endgenerate

   logic [2:0]          state_ff, state_in;
   logic [POS_W-1:0]    pos_ff, pos_in;           // slot index at head
   logic [CMD_W-1:0]    cmd_ff;
   logic [TICKS_W-1:0]  ticks_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [PRIO_W-1:0]   nprio_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [SLOT_W-1:0]   run_ff, run_in;
   logic [CNT_W-1:0]    created_cnt_ff, created_cnt_in;
   logic                need_sw_ff, need_sw_in;
   logic                created_ok_ff, created_ok_in;
   logic [IDX_W-1:0]    created_idx_ff, created_idx_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   best_ff, best_in;
   logic [KEY_W-1:0]    best_key_ff, best_key_in;
   logic [TIME_W-1:0]   mul_time_ff, mul_time_in;
   logic [WEIGHT_W-1:0] mul_w_ff, mul_w_in;
   logic [KEY_W-1:0]    prod_lo_ff, prod_hi_ff;
   logic [SLOT_W-1:0]   prev_ff, prev_in;
   logic [PART_W-1:0]   part_lo, part_hi;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]    rsp_run_ff, rsp_created_ff;
   logic                rsp_sw_ff;

   logic [SLOT_W-1:0]   head_idx;
   logic                head_cur;
   logic                req_take, done_go;
   slot_type            h;
   logic [TIME_W-1:0]   t_new;
   logic [CNT_W-1:0]    y_new;
   logic                idx_ok;

   assign head_idx = pos_ff[SLOT_W-1:0];
   assign head_cur = (head_idx == run_ff);
   assign h        = ring_q[0];
   assign idx_ok   = ({{(32-IDX_W){1'b0}}, idx_ff} < 32'(MAX_THREADS));
   assign req_take = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign done_go  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      shift          = 1'b0;
      head_new       = h;
      run_in         = run_ff;
      created_cnt_in = created_cnt_ff;
      need_sw_in     = need_sw_ff;
      created_ok_in  = created_ok_ff;
      created_idx_in = created_idx_ff;
      stat_in        = stat_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_key_in    = best_key_ff;
      mul_time_in    = mul_time_ff;
      mul_w_in       = mul_w_ff;
      prev_in        = prev_ff;
      t_new          = h.run_time;
      y_new          = h.yields;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in      = S_PASS1;
               pos_in        = '0;
               need_sw_in    = 1'b0;
               created_ok_in = 1'b0;
               created_idx_in = '0;
               stat_in       = ST_OK;
               found_in      = 1'b0;
               prev_in       = run_ff;
               if (req_command == CMD_CREATE) begin
                  stat_in = ST_NO_SLOT;
               end else if ((req_command == CMD_SETPRI) || (req_command == CMD_WAKE)) begin
                  stat_in = ST_BAD_THR;
               end
            end
         end
         S_PASS1: begin
            shift  = 1'b1;
            pos_in = pos_ff + 1'b1;
            priority if (cmd_ff == CMD_CREATE) begin
               if (!h.used && !created_ok_ff) begin
                  head_new.used     = 1'b1;
                  head_new.runnable = 1'b1;
                  head_new.key      = '0;
                  head_new.prio     = PRIO_DEFAULT;
                  head_new.yields   = '0;
                  head_new.run_time = '0;
                  created_ok_in     = 1'b1;
                  created_idx_in    = IDX_W'(head_idx);
                  stat_in           = ST_OK;
                  if (created_cnt_ff != COUNT_MAX) begin
                     created_cnt_in = created_cnt_ff + 1'b1;
                  end
               end
            end else if ((cmd_ff == CMD_YIELD) || (cmd_ff == CMD_BLOCK)) begin
               if (head_cur) begin
                  if ((h.key == '0) && (h.run_time == '0)) begin
                     t_new = TIME_W'(1);
                  end else begin
                     t_new = h.run_time + TIME_W'(ticks_ff);
                  end
                  if (h.yields != COUNT_MAX) begin
                     y_new = h.yields + 1'b1;
                  end
                  head_new.run_time = t_new;
                  head_new.yields   = y_new;
                  if (cmd_ff == CMD_BLOCK) begin
                     head_new.runnable = 1'b0;
                  end
                  if (!((y_new < created_cnt_ff) && (t_new < TIME_W'(limit_ff))
                        && head_new.runnable)) begin
                     need_sw_in        = 1'b1;
                     mul_time_in       = t_new;
                     mul_w_in          = weight_of(h.prio);
                     head_new.yields   = '0;
                     head_new.run_time = '0;
                  end
               end
            end else if ((cmd_ff == CMD_SETPRI) || (cmd_ff == CMD_WAKE)) begin
               if (idx_ok && (IDX_W'(head_idx) == idx_ff) && h.used) begin
                  if (cmd_ff == CMD_WAKE) begin
                     head_new.runnable = 1'b1;
                     stat_in = ST_OK;
                  end else if (nprio_ff > PRIO_MAX) begin
                     stat_in = ST_BAD_PRIO;
                  end else begin
                     head_new.prio = nprio_ff;
                     stat_in = ST_OK;
                  end
               end
            end
            if (pos_ff == POS_W'(MAX_THREADS - 1)) begin
               pos_in   = '0;
               state_in = need_sw_in ? S_MUL0 : S_DONE;
            end
         end
         S_MUL0: begin
            state_in = S_MUL1;
         end
         S_MUL1: begin
            state_in = S_PASS2;
         end
         S_PASS2: begin
            shift  = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (head_cur) begin
               head_new.key = h.key + prod_lo_ff + prod_hi_ff;
            end
            if (head_new.runnable && (!found_ff || (head_new.key < best_key_ff))) begin
               found_in    = 1'b1;
               best_in     = head_idx;
               best_key_in = head_new.key;
            end
            if (pos_ff == POS_W'(MAX_THREADS - 1)) begin
               pos_in   = '0;
               state_in = S_DONE;
               if (found_in) begin
                  run_in = best_in;
               end else begin
                  run_in  = '0;
                  stat_in = ST_NONE_RUN;
               end
            end
         end
         S_DONE: begin
            if (done_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pos_ff         <= '0;
         run_ff         <= '0;
         created_cnt_ff <= CNT_W'(1);
         limit_ff       <= LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         run_ff         <= run_in;
         created_cnt_ff <= created_cnt_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // split 40x24 product into two 20x24 partial products
   assign part_lo = PART_W'(mul_time_ff[19:0]) * PART_W'(mul_w_ff);
   assign part_hi = PART_W'(mul_time_ff[39:20]) * PART_W'(mul_w_ff);

   // payload, work and response registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= req_command;
         ticks_ff <= req_elapsed_ticks;
         idx_ff   <= req_thread_index;
         nprio_ff <= req_new_priority;
      end
      need_sw_ff     <= need_sw_in;
      created_ok_ff  <= created_ok_in;
      created_idx_ff <= created_idx_in;
      stat_ff        <= stat_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      best_key_ff    <= best_key_in;
      mul_time_ff    <= mul_time_in;
      mul_w_ff       <= mul_w_in;
      prev_ff        <= prev_in;
      if (state_ff == S_MUL0) begin
         prod_lo_ff <= KEY_W'(part_lo);
      end
      if (state_ff == S_MUL1) begin
         prod_hi_ff <= KEY_W'({part_hi, 20'd0});
      end
      if (done_go) begin
         rsp_status_ff  <= stat_ff;
         rsp_run_ff     <= IDX_W'(run_ff);
         rsp_sw_ff      <= need_sw_ff && (run_ff != prev_ff);
         rsp_created_ff <= created_idx_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_running_thread = rsp_run_ff;
   assign rsp_switched       = rsp_sw_ff;
   assign rsp_created_thread = rsp_created_ff;

   a_pass_ends_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (pos_ff == '0))
      else $error("ring not realigned at end of request");
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_PASS1))
      else $error("request accepted but scan not started");
   a_mul_before_pass2: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PASS2) && (pos_ff == '0) |-> ($past(state_ff) == S_MUL1))
      else $error("reselection scan started without product");
   a_run_in_range: assert property (@(posedge clock) disable iff (reset)
      ({{(32-SLOT_W){1'b0}}, run_ff} < 32'(MAX_THREADS)))
      else $error("running slot out of range");

endmodule
`default_nettype wire
